// File: hw/rtl/asf_pkg.sv
package asf_pkg;

	localparam int FRAC_BITS_DEF = 32;
	localparam int MUL_LAT = 4;
	localparam int DIV_STEPS = 64;
	localparam int DIV_LAT = DIV_STEPS + 3;
	localparam int SQRT_STEPS = 51;
	localparam int SQRT_RAD_W = 2 * SQRT_STEPS;
	localparam int SQRT_REM_W = SQRT_STEPS + 5;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_INDEX_W-1:0] CFG_AXIAL_STIFFNESS = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_POISSON_RATIO = CFG_INDEX_W'(1);

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
	localparam logic [63:0] Q_MAX = 64'h7FFFFFFFFFFFFFFF;
	localparam logic [63:0] Q_MIN = 64'h8000000000000000;

	function automatic logic [63:0] mag_of(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] signed_sat(input logic neg, input logic [63:0] mag);
		if (!neg) begin
			return mag[63] ? Q_MAX : mag;
		end
		if (mag[63]) begin
			return Q_MIN;
		end
		return 64'd0 - mag;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] sum;
		sum = {a[63], a} + {b[63], b};
		if (sum[64] != sum[63]) begin
			return sum[64] ? Q_MIN : Q_MAX;
		end
		return sum[63:0];
	endfunction

	function automatic logic [63:0] sat_neg(input logic [63:0] a);
		return (a == Q_MIN) ? Q_MAX : (64'd0 - a);
	endfunction

endpackage

// File: hw/rtl/asf_mul.sv
module asf_mul #(
	parameter int FRAC_BITS = asf_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [63:0]  res,
	output logic [127:0] mag
);

	localparam logic [127:0] ROUND_HALF = 128'd1 << (FRAC_BITS - 1);

	logic [63:0]  ma_s1, mb_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  p_ll_s2, p_lh_s2, p_hl_s2, p_hh_s2;
	logic [127:0] prod_s3;
	logic [127:0] full;
	logic [127:0] shifted;

	always_ff @(posedge clk) begin
		ma_s1 <= asf_pkg::mag_of(a);
		mb_s1 <= asf_pkg::mag_of(b);
		neg_s1 <= a[63] ^ b[63];
	end

	always_ff @(posedge clk) begin
		p_ll_s2 <= ma_s1[31:0] * mb_s1[31:0];
		p_lh_s2 <= ma_s1[31:0] * mb_s1[63:32];
		p_hl_s2 <= ma_s1[63:32] * mb_s1[31:0];
		p_hh_s2 <= ma_s1[63:32] * mb_s1[63:32];
		neg_s2 <= neg_s1;
	end

	always_ff @(posedge clk) begin
		prod_s3 <= {64'd0, p_ll_s2} + {32'd0, p_lh_s2, 32'd0} + {32'd0, p_hl_s2, 32'd0}
			+ {p_hh_s2, 64'd0};
		neg_s3 <= neg_s2;
	end

	assign full = prod_s3 + ROUND_HALF;
	assign shifted = full >> FRAC_BITS;

	always_ff @(posedge clk) begin
		mag <= prod_s3;
		if (shifted[127:64] != 64'd0) begin
			res <= neg_s3 ? asf_pkg::Q_MIN : asf_pkg::Q_MAX;
		end else begin
			res <= asf_pkg::signed_sat(neg_s3, shifted[63:0]);
		end
	end

endmodule

// File: hw/rtl/asf_div.sv
module asf_div #(
	parameter int FRAC_BITS = asf_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] quo
);

	localparam int N = asf_pkg::DIV_STEPS;

	logic [63:0] ua_s1, ub_s1;
	logic        neg_s1;

	logic [63:0] rem_q [N+1];
	logic [63:0] lo_q  [N+1];
	logic [63:0] quo_q [N+1];
	logic [63:0] ub_q  [N+1];
	logic        neg_q [N+1];
	logic        zero_q [N+1];
	logic        ovf_q [N+1];

	logic [63:0] hi;

	always_ff @(posedge clk) begin
		ua_s1 <= asf_pkg::mag_of(a);
		ub_s1 <= asf_pkg::mag_of(b);
		neg_s1 <= a[63] ^ b[63];
	end

	assign hi = ua_s1 >> (64 - FRAC_BITS);

	always_ff @(posedge clk) begin
		rem_q[0] <= hi;
		lo_q[0] <= ua_s1 << FRAC_BITS;
		quo_q[0] <= 64'd0;
		ub_q[0] <= ub_s1;
		neg_q[0] <= neg_s1;
		zero_q[0] <= (ub_s1 == 64'd0);
		ovf_q[0] <= (hi >= ub_s1);
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [64:0] t;
		logic        take;
		assign t = {rem_q[k-1], lo_q[k-1][63]};
		assign take = (t >= {1'b0, ub_q[k-1]});
		always_ff @(posedge clk) begin
			rem_q[k] <= take ? 64'(t - {1'b0, ub_q[k-1]}) : t[63:0];
			lo_q[k] <= {lo_q[k-1][62:0], 1'b0};
			quo_q[k] <= {quo_q[k-1][62:0], take};
			ub_q[k] <= ub_q[k-1];
			neg_q[k] <= neg_q[k-1];
			zero_q[k] <= zero_q[k-1];
			ovf_q[k] <= ovf_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_q[N]) begin
			quo <= 64'd0;
		end else if (ovf_q[N]) begin
			quo <= neg_q[N] ? asf_pkg::Q_MIN : asf_pkg::Q_MAX;
		end else begin
			quo <= asf_pkg::signed_sat(neg_q[N], quo_q[N]);
		end
	end

endmodule

// File: hw/rtl/axisym_shell_stretch_force.sv
// Stretching force of one axisymmetric shell edge.
// Command channel: an edge transfers at a rising edge with start high and busy
// low. busy stays low, so one edge may be issued in every cycle.
// Result channel: done is high for one cycle with dof_a_base, dof_b_base, the
// four force components and degenerate; the receiver takes it in that cycle.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (axial stiffness, Poisson ratio); unknown indexes are dropped.
// Each edge passes through the chain square -> root -> divide -> multiply ->
// multiply -> divide -> multiply. Throughput: one edge per cycle, every unit
// is fully pipelined (one root bit and one quotient bit per stage, 32x32
// partial products in the multipliers).
// Reset: arst_n clears the two configuration registers and the valid line;
// no result is lost or repeated since the pipeline never stalls.
module axisym_shell_stretch_force #(
	parameter int FRAC_BITS = asf_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [asf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [asf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [15:0]                       node_a_index,
	input  logic [15:0]                       node_b_index,
	input  logic [47:0]                       node_a_radial,
	input  logic [47:0]                       node_a_axial,
	input  logic [47:0]                       node_b_radial,
	input  logic [47:0]                       node_b_axial,
	input  logic [46:0]                       rest_length,
	input  logic [46:0]                       rest_radius_a,
	input  logic [46:0]                       rest_radius_b,
	output logic                              done,
	output logic [16:0]                       dof_a_base,
	output logic [16:0]                       dof_b_base,
	output logic [63:0]                       force_a_radial,
	output logic [63:0]                       force_a_axial,
	output logic [63:0]                       force_b_radial,
	output logic [63:0]                       force_b_axial,
	output logic                              degenerate
);

	localparam int ML = asf_pkg::MUL_LAT;
	localparam int DL = asf_pkg::DIV_LAT;
	localparam int SN = asf_pkg::SQRT_STEPS;
	localparam int RW = asf_pkg::SQRT_RAD_W;
	localparam int EW = asf_pkg::SQRT_REM_W;
	localparam int DLY_A = ML + 2 + SN;
	localparam int LAT_TOTAL = 9 + 4 * ML + 2 * DL + SN;
	localparam logic [63:0] HALF_PI =
		(asf_pkg::PI_Q62 + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS);

	typedef struct packed {
		logic [15:0] ia;
		logic [15:0] ib;
		logic [63:0] pa_r;
		logic [63:0] pb_r;
		logic [63:0] lb;
		logic [63:0] r1;
		logic [63:0] r2;
		logic [63:0] dx;
		logic [63:0] dy;
	} a_t;

	typedef struct packed {
		logic [15:0] ia;
		logic [15:0] ib;
		logic        degen;
		logic [63:0] lb;
		logic [63:0] r1;
		logic [63:0] r2;
	} b_t;

	typedef struct packed {
		logic [15:0] ia;
		logic [15:0] ib;
		logic        degen;
		logic [63:0] lb;
		logic [63:0] r1;
		logic [63:0] r2;
		logic [63:0] r12;
		logic [63:0] ux;
		logic [63:0] uy;
		logic [63:0] e;
		logic [63:0] s;
		logic [63:0] s2x;
	} c_t;

	typedef struct packed {
		logic [15:0] ia;
		logic [15:0] ib;
		logic        degen;
		logic [63:0] r1;
		logic [63:0] r2;
	} d_t;

	typedef struct packed {
		logic [15:0] ia;
		logic [15:0] ib;
		logic        degen;
		logic [63:0] uxp;
		logic [63:0] f1;
		logic [63:0] g;
	} e_t;

	typedef struct packed {
		logic [15:0] ia;
		logic [15:0] ib;
		logic        degen;
	} f_t;

	logic [47:0]          ea_q;
	logic [15:0]          mu_q;
	logic [LAT_TOTAL-1:0] vld_q;
	logic [63:0]          mu_w, ea_w;

	a_t in_s1;
	a_t dly_a_q [DLY_A];
	b_t b_s3;
	b_t dly_b_q [DL];
	c_t c_s4;
	c_t dly_c_q [ML];
	d_t d_s5;
	d_t dly_d_q [ML];
	e_t e_s6;
	e_t dly_e_q [DL];
	f_t f_s7;
	f_t dly_f_q [ML];

	logic [127:0] sqx_w, sqy_w;
	logic [127:0] sumsq_s2;
	logic [RW-1:0] rad_q [SN+1];
	logic [EW-1:0] rem_q [SN+1];
	logic [SN-1:0] root_q [SN+1];

	logic [63:0] len_w;
	logic [63:0] dx_s3, dy_s3, len_s3, nr1_s3, nr2_s3, nl_s3;
	logic [63:0] ux_w, uy_w, e1_w, e2_w, s_w;
	logic [63:0] mue_w, mus_w, hpea_w;
	logic [63:0] p_s5, q_s5, hpea_s5, r12_s5, ux_s5, uy_s5, lb_s5;
	logic [63:0] ql_w, uxp_w, f1_w, gm_w;
	logic [63:0] ql_s6;
	logic [63:0] q1_w, q2_w;
	logic [63:0] f0_s7, f1_s7, f2_s7, f3_s7, g_s7;
	logic [63:0] fr0_w, fr1_w, fr2_w, fr3_w;

	function automatic logic [63:0] half_trunc(input logic [63:0] v);
		logic [63:0] t;
		t = v + {63'd0, v[63]};
		return {t[63], t[63:1]};
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ea_q <= 48'd0;
			mu_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				asf_pkg::CFG_AXIAL_STIFFNESS: ea_q <= cfg_data;
				asf_pkg::CFG_POISSON_RATIO: mu_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign mu_w = {48'd0, mu_q} << (FRAC_BITS - 16);
	assign ea_w = {16'd0, ea_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT_TOTAL-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		in_s1.ia <= node_a_index;
		in_s1.ib <= node_b_index;
		in_s1.pa_r <= {{16{node_a_radial[47]}}, node_a_radial};
		in_s1.pb_r <= {{16{node_b_radial[47]}}, node_b_radial};
		in_s1.lb <= {17'd0, rest_length};
		in_s1.r1 <= {17'd0, rest_radius_a};
		in_s1.r2 <= {17'd0, rest_radius_b};
		in_s1.dx <= {{16{node_b_radial[47]}}, node_b_radial}
			- {{16{node_a_radial[47]}}, node_a_radial};
		in_s1.dy <= {{16{node_b_axial[47]}}, node_b_axial}
			- {{16{node_a_axial[47]}}, node_a_axial};
	end

	always_ff @(posedge clk) dly_a_q[0] <= in_s1;
	for (genvar k = 1; k < DLY_A; k++) begin : g_dly_a
		always_ff @(posedge clk) dly_a_q[k] <= dly_a_q[k-1];
	end

	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_sq_x (
		.clk(clk), .a(in_s1.dx), .b(in_s1.dx), .res(), .mag(sqx_w)
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_sq_y (
		.clk(clk), .a(in_s1.dy), .b(in_s1.dy), .res(), .mag(sqy_w)
	);

	always_ff @(posedge clk) sumsq_s2 <= sqx_w + sqy_w;

	always_ff @(posedge clk) begin
		rad_q[0] <= sumsq_s2[RW-1:0];
		rem_q[0] <= '0;
		root_q[0] <= '0;
	end

	for (genvar k = 1; k <= SN; k++) begin : g_root
		logic [EW-1:0] cur;
		logic [EW-1:0] trial;
		logic          take;
		assign cur = {rem_q[k-1][EW-3:0], rad_q[k-1][RW-1:RW-2]};
		assign trial = {1'b0, root_q[k-1], 2'b01};
		assign take = (cur >= trial);
		always_ff @(posedge clk) begin
			rad_q[k] <= {rad_q[k-1][RW-3:0], 2'b00};
			rem_q[k] <= take ? (cur - trial) : cur;
			root_q[k] <= {root_q[k-1][SN-2:0], take};
		end
	end

	assign len_w = {{(64 - SN){1'b0}}, root_q[SN]};

	always_ff @(posedge clk) begin
		b_s3.ia <= dly_a_q[DLY_A-1].ia;
		b_s3.ib <= dly_a_q[DLY_A-1].ib;
		b_s3.degen <= (len_w == 64'd0) || (dly_a_q[DLY_A-1].r1 == 64'd0)
			|| (dly_a_q[DLY_A-1].r2 == 64'd0) || (dly_a_q[DLY_A-1].lb == 64'd0);
		b_s3.lb <= dly_a_q[DLY_A-1].lb;
		b_s3.r1 <= dly_a_q[DLY_A-1].r1;
		b_s3.r2 <= dly_a_q[DLY_A-1].r2;
		dx_s3 <= dly_a_q[DLY_A-1].dx;
		dy_s3 <= dly_a_q[DLY_A-1].dy;
		len_s3 <= len_w;
		nr1_s3 <= dly_a_q[DLY_A-1].pa_r - dly_a_q[DLY_A-1].r1;
		nr2_s3 <= dly_a_q[DLY_A-1].pb_r - dly_a_q[DLY_A-1].r2;
		nl_s3 <= len_w - dly_a_q[DLY_A-1].lb;
	end

	asf_div #(.FRAC_BITS(FRAC_BITS)) u_div_ux (.clk(clk), .a(dx_s3), .b(len_s3), .quo(ux_w));
	asf_div #(.FRAC_BITS(FRAC_BITS)) u_div_uy (.clk(clk), .a(dy_s3), .b(len_s3), .quo(uy_w));
	asf_div #(.FRAC_BITS(FRAC_BITS)) u_div_e1 (.clk(clk), .a(nr1_s3), .b(b_s3.r1), .quo(e1_w));
	asf_div #(.FRAC_BITS(FRAC_BITS)) u_div_e2 (.clk(clk), .a(nr2_s3), .b(b_s3.r2), .quo(e2_w));
	asf_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (.clk(clk), .a(nl_s3), .b(b_s3.lb), .quo(s_w));

	always_ff @(posedge clk) dly_b_q[0] <= b_s3;
	for (genvar k = 1; k < DL; k++) begin : g_dly_b
		always_ff @(posedge clk) dly_b_q[k] <= dly_b_q[k-1];
	end

	always_ff @(posedge clk) begin
		c_s4.ia <= dly_b_q[DL-1].ia;
		c_s4.ib <= dly_b_q[DL-1].ib;
		c_s4.degen <= dly_b_q[DL-1].degen;
		c_s4.lb <= dly_b_q[DL-1].lb;
		c_s4.r1 <= dly_b_q[DL-1].r1;
		c_s4.r2 <= dly_b_q[DL-1].r2;
		c_s4.r12 <= dly_b_q[DL-1].r1 + dly_b_q[DL-1].r2;
		c_s4.ux <= ux_w;
		c_s4.uy <= uy_w;
		c_s4.e <= asf_pkg::sat_add(e1_w, e2_w);
		c_s4.s <= s_w;
		c_s4.s2x <= asf_pkg::sat_add(s_w, s_w);
	end

	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_mue (
		.clk(clk), .a(mu_w), .b(c_s4.e), .res(mue_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_mus (
		.clk(clk), .a(mu_w), .b(c_s4.s), .res(mus_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hpea (
		.clk(clk), .a(HALF_PI), .b(ea_w), .res(hpea_w), .mag()
	);

	always_ff @(posedge clk) dly_c_q[0] <= c_s4;
	for (genvar k = 1; k < ML; k++) begin : g_dly_c
		always_ff @(posedge clk) dly_c_q[k] <= dly_c_q[k-1];
	end

	always_ff @(posedge clk) begin
		p_s5 <= asf_pkg::sat_neg(asf_pkg::sat_add(mue_w, dly_c_q[ML-1].s2x));
		q_s5 <= asf_pkg::sat_add(half_trunc(dly_c_q[ML-1].e), mus_w);
		hpea_s5 <= hpea_w;
		r12_s5 <= dly_c_q[ML-1].r12;
		ux_s5 <= dly_c_q[ML-1].ux;
		uy_s5 <= dly_c_q[ML-1].uy;
		lb_s5 <= dly_c_q[ML-1].lb;
		d_s5.ia <= dly_c_q[ML-1].ia;
		d_s5.ib <= dly_c_q[ML-1].ib;
		d_s5.degen <= dly_c_q[ML-1].degen;
		d_s5.r1 <= dly_c_q[ML-1].r1;
		d_s5.r2 <= dly_c_q[ML-1].r2;
	end

	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ql (
		.clk(clk), .a(q_s5), .b(lb_s5), .res(ql_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uxp (
		.clk(clk), .a(ux_s5), .b(p_s5), .res(uxp_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_f1 (
		.clk(clk), .a(uy_s5), .b(p_s5), .res(f1_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_g (
		.clk(clk), .a(hpea_s5), .b(r12_s5), .res(gm_w), .mag()
	);

	always_ff @(posedge clk) dly_d_q[0] <= d_s5;
	for (genvar k = 1; k < ML; k++) begin : g_dly_d
		always_ff @(posedge clk) dly_d_q[k] <= dly_d_q[k-1];
	end

	always_ff @(posedge clk) begin
		ql_s6 <= ql_w;
		e_s6.ia <= dly_d_q[ML-1].ia;
		e_s6.ib <= dly_d_q[ML-1].ib;
		e_s6.degen <= dly_d_q[ML-1].degen;
		e_s6.uxp <= uxp_w;
		e_s6.f1 <= f1_w;
		e_s6.g <= asf_pkg::sat_neg(gm_w);
	end

	logic [63:0] r1_s6, r2_s6;
	always_ff @(posedge clk) begin
		r1_s6 <= dly_d_q[ML-1].r1;
		r2_s6 <= dly_d_q[ML-1].r2;
	end

	asf_div #(.FRAC_BITS(FRAC_BITS)) u_div_q1 (.clk(clk), .a(ql_s6), .b(r1_s6), .quo(q1_w));
	asf_div #(.FRAC_BITS(FRAC_BITS)) u_div_q2 (.clk(clk), .a(ql_s6), .b(r2_s6), .quo(q2_w));

	always_ff @(posedge clk) dly_e_q[0] <= e_s6;
	for (genvar k = 1; k < DL; k++) begin : g_dly_e
		always_ff @(posedge clk) dly_e_q[k] <= dly_e_q[k-1];
	end

	always_ff @(posedge clk) begin
		f0_s7 <= asf_pkg::sat_add(q1_w, dly_e_q[DL-1].uxp);
		f2_s7 <= asf_pkg::sat_add(q2_w, asf_pkg::sat_neg(dly_e_q[DL-1].uxp));
		f1_s7 <= dly_e_q[DL-1].f1;
		f3_s7 <= asf_pkg::sat_neg(dly_e_q[DL-1].f1);
		g_s7 <= dly_e_q[DL-1].g;
		f_s7.ia <= dly_e_q[DL-1].ia;
		f_s7.ib <= dly_e_q[DL-1].ib;
		f_s7.degen <= dly_e_q[DL-1].degen;
	end

	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fr0 (
		.clk(clk), .a(g_s7), .b(f0_s7), .res(fr0_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fr1 (
		.clk(clk), .a(g_s7), .b(f1_s7), .res(fr1_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fr2 (
		.clk(clk), .a(g_s7), .b(f2_s7), .res(fr2_w), .mag()
	);
	asf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_fr3 (
		.clk(clk), .a(g_s7), .b(f3_s7), .res(fr3_w), .mag()
	);

	always_ff @(posedge clk) dly_f_q[0] <= f_s7;
	for (genvar k = 1; k < ML; k++) begin : g_dly_f
		always_ff @(posedge clk) dly_f_q[k] <= dly_f_q[k-1];
	end

	always_ff @(posedge clk) begin
		dof_a_base <= {dly_f_q[ML-1].ia, 1'b0};
		dof_b_base <= {dly_f_q[ML-1].ib, 1'b0};
		degenerate <= dly_f_q[ML-1].degen;
		force_a_radial <= dly_f_q[ML-1].degen ? 64'd0 : fr0_w;
		force_a_axial <= dly_f_q[ML-1].degen ? 64'd0 : fr1_w;
		force_b_radial <= dly_f_q[ML-1].degen ? 64'd0 : fr2_w;
		force_b_axial <= dly_f_q[ML-1].degen ? 64'd0 : fr3_w;
	end

	assign done = vld_q[LAT_TOTAL-1];

endmodule
